>>> design/dh_link_transform_core_macros.svh
// Assertion macros shared by the link transform design.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef DH_LINK_TRANSFORM_CORE_MACROS_SVH
`define DH_LINK_TRANSFORM_CORE_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold on every clock edge outside reset.
`define DHLT_ASSERT_HOLD(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dhlt: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define DHLT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dhlt: same-cycle implication violated");

// A consequence that must hold in the cycle after its cause.
`define DHLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dhlt: next-cycle implication violated");

`else

`define DHLT_ASSERT_HOLD(label, cond)
`define DHLT_ASSERT_NOW(label, ante, cons)
`define DHLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/dhlt_pkg.sv
`timescale 1ns / 1ps

package dhlt_pkg;

	// Default field widths.
	localparam int ANGLE_BITS_DEF  = 16;
	localparam int LENGTH_BITS_DEF = 32;

	// Trig values are signed Q1.15.
	localparam int TRIG_BITS = 16;

	// Internal sine arithmetic works on unsigned Q30 words with one guard bit.
	localparam int Q30_BITS = 31;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_BASE_THETA    = 2'd0,
		CFG_BASE_ALPHA    = 2'd1,
		CFG_BASE_LENGTH_A = 2'd2,
		CFG_BASE_OFFSET_D = 2'd3
	} cfg_reg_t;

	// Odd Taylor series of sin(t*pi/2) in Q30, evaluated by Horner on t*t.
	// The highest coefficient starts the chain; each cell folds in one more.
	localparam int HORNER_STEPS = 4;
	localparam logic [Q30_BITS-1:0] HORNER_START = 31'd172272;
	localparam logic [Q30_BITS-1:0] HORNER_COEF [HORNER_STEPS] = '{
		31'd5026995,
		31'd85569306,
		31'd693598668,
		31'd1686629713
	};

	// One sine evaluation as it travels along the chain of cells.
	typedef struct packed {
		logic [1:0]          quad;
		logic [Q30_BITS-1:0] t;
		logic [Q30_BITS-1:0] s;
		logic [Q30_BITS-1:0] p;
	} sin_lane_t;

	// Q30 product, rounded half up. Operands stay in the range where the
	// rounded result fits the word.
	function automatic logic [Q30_BITS-1:0] mul30(input logic [Q30_BITS-1:0] a,
		input logic [Q30_BITS-1:0] b);
		logic [2*Q30_BITS-1:0] prod;
		prod = (2*Q30_BITS)'(a) * (2*Q30_BITS)'(b) + ((2*Q30_BITS)'(1) << 29);
		return prod[Q30_BITS+29:30];
	endfunction

endpackage

>>> design/dhlt_ifs.sv
`timescale 1ns / 1ps

// Joint word: offsets added to the link constants.
interface dhlt_joint_if #(
	parameter int ANGLE_BITS  = dhlt_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_BITS-1:0]  joint_theta;
	logic signed [ANGLE_BITS-1:0]  joint_alpha;
	logic signed [LENGTH_BITS-1:0] joint_a;
	logic signed [LENGTH_BITS-1:0] joint_d;

	modport source (output valid, joint_theta, joint_alpha, joint_a, joint_d, input ready);
	modport sink (input valid, joint_theta, joint_alpha, joint_a, joint_d, output ready);
endinterface

// Link word: the eleven varying entries of the link transform.
interface dhlt_link_if #(
	parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF
);
	logic                                    valid;
	logic                                    ready;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r00;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r01;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r02;
	logic signed [LENGTH_BITS-1:0]           tx;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r10;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r11;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r12;
	logic signed [LENGTH_BITS-1:0]           ty;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r21;
	logic signed [dhlt_pkg::TRIG_BITS-1:0]   r22;
	logic signed [LENGTH_BITS-1:0]           tz;

	modport source (output valid, r00, r01, r02, tx, r10, r11, r12, ty, r21, r22, tz,
		input ready);
	modport sink (input valid, r00, r01, r02, tx, r10, r11, r12, ty, r21, r22, tz,
		output ready);
endinterface

>>> design/dhlt_prep_cell.sv
`timescale 1ns / 1ps

// First cell of a sine lane: folds the angle into the first quadrant,
// forms t and t*t in Q30 and seeds the Horner accumulator.
module dhlt_prep_cell #(
	parameter int ANGLE_BITS = dhlt_pkg::ANGLE_BITS_DEF,
	parameter bit QUARTER    = 1'b0
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ANGLE_BITS-1:0]     ang,
	output dhlt_pkg::sin_lane_t       lane
);

	localparam logic [ANGLE_BITS-1:0] QTURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
	localparam logic [dhlt_pkg::Q30_BITS-1:0] ONE_Q30 = dhlt_pkg::Q30_BITS'(1) << 30;

	logic [ANGLE_BITS-1:0]          ang_ph;
	logic [1:0]                     quad;
	logic [29:0]                    t_raw;
	logic [dhlt_pkg::Q30_BITS-1:0]  t_fold;
	dhlt_pkg::sin_lane_t            lane_q;

	function automatic logic [ANGLE_BITS-1:0] ang_ph_add(input logic [ANGLE_BITS-1:0] x);
		return x + QTURN;
	endfunction

	// Cosine lanes run a quarter turn ahead; the sum wraps.
	assign ang_ph = QUARTER ? ang_ph_add(ang) : ang;

	// Quadrant from the top bits, the rest scaled to a Q30 fraction.
	assign quad   = ang_ph[ANGLE_BITS-1:ANGLE_BITS-2];
	assign t_raw  = {ang_ph[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
	assign t_fold = quad[0] ? (ONE_Q30 - {1'b0, t_raw}) : {1'b0, t_raw};

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.quad <= quad;
			lane_q.t    <= t_fold;
			lane_q.s    <= dhlt_pkg::mul30(t_fold, t_fold);
			lane_q.p    <= dhlt_pkg::HORNER_START;
		end
	end

	assign lane = lane_q;

endmodule

>>> design/dhlt_horner_cell.sv
`timescale 1ns / 1ps

// One Horner step of the sine series: p <- c - p*s, everything else
// handed on to the next cell unchanged.
module dhlt_horner_cell #(
	parameter int STEP = 0
) (
	input  logic                clk,
	input  logic                en,
	input  dhlt_pkg::sin_lane_t lane_in,
	output dhlt_pkg::sin_lane_t lane_out
);

	localparam logic [dhlt_pkg::Q30_BITS-1:0] COEF = dhlt_pkg::HORNER_COEF[STEP];

	dhlt_pkg::sin_lane_t lane_q;

	always_ff @(posedge clk) begin
		if (en) begin
			lane_q.quad <= lane_in.quad;
			lane_q.t    <= lane_in.t;
			lane_q.s    <= lane_in.s;
			lane_q.p    <= COEF - dhlt_pkg::mul30(lane_in.p, lane_in.s);
		end
	end

	assign lane_out = lane_q;

endmodule

>>> design/dhlt_finish_cell.sv
`timescale 1ns / 1ps

// Last two cells of a sine lane: multiply the series by t, then round
// to Q1.15, saturate at +1 and apply the sign of the half turn.
module dhlt_finish_cell (
	input  logic                                 clk,
	input  logic                                 en_mul,
	input  logic                                 en_rnd,
	input  dhlt_pkg::sin_lane_t                  lane,
	output logic signed [dhlt_pkg::TRIG_BITS-1:0] trig
);

	localparam logic [16:0] TRIG_MAX = 17'd32767;

	logic [dhlt_pkg::Q30_BITS-1:0]         v_s1;
	logic [1:0]                            quad_s1;
	logic [31:0]                           v_rnd;
	logic [16:0]                           mag;
	logic [dhlt_pkg::TRIG_BITS-1:0]        mag_sat;
	logic signed [dhlt_pkg::TRIG_BITS-1:0] trig_s2;

	// Series times t, still Q30.
	always_ff @(posedge clk) begin
		if (en_mul) begin
			v_s1    <= dhlt_pkg::mul30(lane.p, lane.t);
			quad_s1 <= lane.quad;
		end
	end

	// Round half up to Q15 and clamp at 32767.
	assign v_rnd   = 32'(v_s1) + 32'd16384;
	assign mag     = v_rnd[31:15];
	assign mag_sat = (mag > TRIG_MAX) ? TRIG_MAX[15:0] : mag[15:0];

	always_ff @(posedge clk) begin
		if (en_rnd) begin
			trig_s2 <= quad_s1[1] ? -$signed(mag_sat) : $signed(mag_sat);
		end
	end

	assign trig = trig_s2;

endmodule

>>> design/dh_link_transform_core.sv
`timescale 1ns / 1ps
`include "dh_link_transform_core_macros.svh"

// Denavit-Hartenberg link transform.
// The joint channel takes one word of theta, alpha, a and d offsets; these
// are added to the link constants written through the configuration port
// (angles wrap over a full turn, lengths saturate). The link channel gives
// the eleven varying entries of the 4x4 link matrix for each joint word.
// Both channels move a word when valid and ready are high at a clock edge.
// A word accepted on the joint channel passes the sum stage, seven sine
// cells in each sine lane (fold, four Horner steps, multiply, round), the
// product stage and the output register. A new word can enter every cycle
// while a stage is free or the receiver takes words. When the receiver
// holds ready low, words close up into empty stages and joint ready stays
// high until all ten stages are full. Configuration is to be written only
// while the block is empty; the block itself does not enforce this. Reset
// clears the link constants to zero and empties the pipeline; there is no clearing pass.
module dh_link_transform_core #(
	parameter int ANGLE_BITS  = dhlt_pkg::ANGLE_BITS_DEF,
	parameter int LENGTH_BITS = dhlt_pkg::LENGTH_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [dhlt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [((ANGLE_BITS > LENGTH_BITS) ? ANGLE_BITS : LENGTH_BITS)-1:0] cfg_data,
	dhlt_joint_if.sink                            joint,
	dhlt_link_if.source                           link
);

	localparam int NSTG     = 10;
	localparam int LANES    = 4;
	localparam int LINE_LEN = 7;
	localparam int LANE_ST  = 0;
	localparam int LANE_CT  = 1;
	localparam int LANE_SA  = 2;
	localparam int LANE_CA  = 3;
	localparam int TB       = dhlt_pkg::TRIG_BITS;

	localparam logic signed [LENGTH_BITS-1:0] LEN_MAX = {1'b0, {(LENGTH_BITS-1){1'b1}}};
	localparam logic signed [LENGTH_BITS-1:0] LEN_MIN = {1'b1, {(LENGTH_BITS-1){1'b0}}};

	typedef struct packed {
		logic signed [LENGTH_BITS-1:0] a;
		logic signed [LENGTH_BITS-1:0] d;
	} len_pair_t;

	// Saturating length sum.
	function automatic logic signed [LENGTH_BITS-1:0] sat_add(
		input logic signed [LENGTH_BITS-1:0] x,
		input logic signed [LENGTH_BITS-1:0] y);
		logic signed [LENGTH_BITS:0] sum;
		sum = (LENGTH_BITS+1)'(x) + (LENGTH_BITS+1)'(y);
		if (sum[LENGTH_BITS] != sum[LENGTH_BITS-1]) begin
			return sum[LENGTH_BITS] ? LEN_MIN : LEN_MAX;
		end
		return sum[LENGTH_BITS-1:0];
	endfunction

	// Q1.15 product back to Q1.15, rounded half up.
	function automatic logic signed [TB-1:0] rnd_q15(input logic signed [32:0] x);
		logic signed [32:0] y;
		y = x + 33'sd16384;
		return y[30:15];
	endfunction

	// Length times trig value back to Q16.16, rounded half up and saturated.
	function automatic logic signed [LENGTH_BITS-1:0] rnd_len(
		input logic signed [LENGTH_BITS+TB-1:0] x);
		logic signed [LENGTH_BITS+TB:0]  y;
		logic signed [LENGTH_BITS+1:0]   q;
		y = (LENGTH_BITS+TB+1)'(x) + (LENGTH_BITS+TB+1)'(16384);
		q = y[LENGTH_BITS+TB:15];
		if ((q[LENGTH_BITS+1] != q[LENGTH_BITS]) || (q[LENGTH_BITS] != q[LENGTH_BITS-1])) begin
			return q[LENGTH_BITS+1] ? LEN_MIN : LEN_MAX;
		end
		return q[LENGTH_BITS-1:0];
	endfunction

	logic [ANGLE_BITS-1:0]         base_theta_q;
	logic [ANGLE_BITS-1:0]         base_alpha_q;
	logic signed [LENGTH_BITS-1:0] base_length_a_q;
	logic signed [LENGTH_BITS-1:0] base_offset_d_q;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	logic [ANGLE_BITS-1:0]         th_s1;
	logic [ANGLE_BITS-1:0]         al_s1;
	len_pair_t                     len_s1;
	len_pair_t                     len_line_q [LINE_LEN];

	dhlt_pkg::sin_lane_t           chain [LANES][dhlt_pkg::HORNER_STEPS+1];
	logic signed [TB-1:0]          trig [LANES];

	logic signed [TB-1:0]            st_s9, ct_s9, sa_s9, ca_s9;
	logic signed [31:0]              stca_s9, stsa_s9, ctca_s9, ctsa_s9;
	logic signed [LENGTH_BITS+TB-1:0] act_s9, ast_s9;
	logic signed [LENGTH_BITS-1:0]   d_s9;

	logic signed [TB-1:0]          r00_s10, r01_s10, r02_s10, r10_s10, r11_s10, r12_s10;
	logic signed [TB-1:0]          r21_s10, r22_s10;
	logic signed [LENGTH_BITS-1:0] tx_s10, ty_s10, tz_s10;

	// Link constants, to be written only while the block is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_theta_q    <= '0;
			base_alpha_q    <= '0;
			base_length_a_q <= '0;
			base_offset_d_q <= '0;
		end else if (cfg_write) begin
			unique case (dhlt_pkg::cfg_reg_t'(cfg_index))
				dhlt_pkg::CFG_BASE_THETA:    base_theta_q    <= cfg_data[ANGLE_BITS-1:0];
				dhlt_pkg::CFG_BASE_ALPHA:    base_alpha_q    <= cfg_data[ANGLE_BITS-1:0];
				dhlt_pkg::CFG_BASE_LENGTH_A: base_length_a_q <= cfg_data[LENGTH_BITS-1:0];
				dhlt_pkg::CFG_BASE_OFFSET_D: base_offset_d_q <= cfg_data[LENGTH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its word moves on.
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || link.ready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign joint.ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= joint.valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// Stage 1: joint offsets added to the link constants.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			th_s1    <= base_theta_q + joint.joint_theta;
			al_s1    <= base_alpha_q + joint.joint_alpha;
			len_s1.a <= sat_add(base_length_a_q, joint.joint_a);
			len_s1.d <= sat_add(base_offset_d_q, joint.joint_d);
		end
	end

	// Lengths wait alongside the sine cells.
	for (genvar k = 0; k < LINE_LEN; k++) begin : g_len_line
		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				len_line_q[k] <= (k == 0) ? len_s1 : len_line_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Four sine lanes: sin theta, cos theta, sin alpha, cos alpha.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		dhlt_prep_cell #(
			.ANGLE_BITS (ANGLE_BITS),
			.QUARTER    (g % 2 == 1)
		) u_prep (
			.clk  (clk),
			.en   (en[1]),
			.ang  ((g < 2) ? th_s1 : al_s1),
			.lane (chain[g][0])
		);

		for (genvar h = 0; h < dhlt_pkg::HORNER_STEPS; h++) begin : g_step
			dhlt_horner_cell #(
				.STEP (h)
			) u_horner (
				.clk      (clk),
				.en       (en[2+h]),
				.lane_in  (chain[g][h]),
				.lane_out (chain[g][h+1])
			);
		end

		dhlt_finish_cell u_finish (
			.clk    (clk),
			.en_mul (en[2+dhlt_pkg::HORNER_STEPS]),
			.en_rnd (en[3+dhlt_pkg::HORNER_STEPS]),
			.lane   (chain[g][dhlt_pkg::HORNER_STEPS]),
			.trig   (trig[g])
		);
	end

	// Stage 9: rotation and translation products.
	always_ff @(posedge clk) begin
		if (en[8]) begin
			st_s9   <= trig[LANE_ST];
			ct_s9   <= trig[LANE_CT];
			sa_s9   <= trig[LANE_SA];
			ca_s9   <= trig[LANE_CA];
			stca_s9 <= trig[LANE_ST] * trig[LANE_CA];
			stsa_s9 <= trig[LANE_ST] * trig[LANE_SA];
			ctca_s9 <= trig[LANE_CT] * trig[LANE_CA];
			ctsa_s9 <= trig[LANE_CT] * trig[LANE_SA];
			act_s9  <= len_line_q[LINE_LEN-1].a * trig[LANE_CT];
			ast_s9  <= len_line_q[LINE_LEN-1].a * trig[LANE_ST];
			d_s9    <= len_line_q[LINE_LEN-1].d;
		end
	end

	// Stage 10: rounding into the output register.
	always_ff @(posedge clk) begin
		if (en[9]) begin
			r00_s10 <= ct_s9;
			r01_s10 <= rnd_q15(-33'(stca_s9));
			r02_s10 <= rnd_q15(33'(stsa_s9));
			tx_s10  <= rnd_len(act_s9);
			r10_s10 <= st_s9;
			r11_s10 <= rnd_q15(33'(ctca_s9));
			r12_s10 <= rnd_q15(-33'(ctsa_s9));
			ty_s10  <= rnd_len(ast_s9);
			r21_s10 <= sa_s9;
			r22_s10 <= ca_s9;
			tz_s10  <= d_s9;
		end
	end

	assign link.valid = vld_q[NSTG-1];
	assign link.r00   = r00_s10;
	assign link.r01   = r01_s10;
	assign link.r02   = r02_s10;
	assign link.tx    = tx_s10;
	assign link.r10   = r10_s10;
	assign link.r11   = r11_s10;
	assign link.r12   = r12_s10;
	assign link.ty    = ty_s10;
	assign link.r21   = r21_s10;
	assign link.r22   = r22_s10;
	assign link.tz    = tz_s10;

	// An accepted joint word occupies the first stage on the next cycle.
	`DHLT_ASSERT_NEXT(a_accept_fills_s1, joint.valid && joint.ready, vld_q[0])

	// With every stage full and the receiver stalled, no word may enter.
	`DHLT_ASSERT_NOW(a_full_blocks_input, (&vld_q) && !link.ready, !joint.ready)

	// A new link word only appears after the product stage held a word.
	`DHLT_ASSERT_NOW(a_out_from_s9, $rose(link.valid), $past(vld_q[NSTG-2]))

	// The sine and cosine entries are clamped at plus and minus one, never the most negative code.
	`DHLT_ASSERT_NOW(a_trig_clamped, link.valid, (link.r00 != 16'sh8000) && (link.r10 != 16'sh8000) && (link.r21 != 16'sh8000) && (link.r22 != 16'sh8000))

endmodule

>>> sim/tb_dh_link_transform_core.sv
`timescale 1ns / 1ps

module tb_dh_link_transform_core;

	localparam int ANG_W = dhlt_pkg::ANGLE_BITS_DEF;
	localparam int LEN_W = dhlt_pkg::LENGTH_BITS_DEF;
	localparam int TRG_W = dhlt_pkg::TRIG_BITS;
	localparam int CFG_W = (ANG_W > LEN_W) ? ANG_W : LEN_W;

	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 14;
	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 50;
	localparam int RANDOM_PER_SET = 275;

	localparam longint LEN_MAX = (longint'(1) << (LEN_W - 1)) - 1;
	localparam longint LEN_MIN = -LEN_MAX - 1;
	localparam logic [LEN_W-1:0] LEN_MAX_WORD = {1'b0, {(LEN_W-1){1'b1}}};
	localparam logic [LEN_W-1:0] LEN_MIN_WORD = {1'b1, {(LEN_W-1){1'b0}}};

	localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(1) << (ANG_W - 2);

	// Sine series coefficients in Q30, highest order first.
	localparam logic [63:0] SINE_C9 = 64'd172272;
	localparam logic [63:0] SINE_C7 = 64'd5026995;
	localparam logic [63:0] SINE_C5 = 64'd85569306;
	localparam logic [63:0] SINE_C3 = 64'd693598668;
	localparam logic [63:0] SINE_C1 = 64'd1686629713;

	localparam logic [15:0] ANGLE_CORNERS [8] = '{
		16'h0000, 16'h4000, 16'h8000, 16'hC000,
		16'h7FFF, 16'h8001, 16'hFFFF, 16'h0001
	};
	localparam logic [31:0] LENGTH_CORNERS [8] = '{
		32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000001,
		32'hFFFFFFFF, 32'h00010000, 32'hFFFF0000, 32'h40000000
	};

	typedef struct packed {
		logic [ANG_W-1:0] theta;
		logic [ANG_W-1:0] alpha;
		logic [LEN_W-1:0] len_a;
		logic [LEN_W-1:0] off_d;
	} joint_word_t;

	typedef struct packed {
		logic [TRG_W-1:0] r00;
		logic [TRG_W-1:0] r01;
		logic [TRG_W-1:0] r02;
		logic [LEN_W-1:0] tx;
		logic [TRG_W-1:0] r10;
		logic [TRG_W-1:0] r11;
		logic [TRG_W-1:0] r12;
		logic [LEN_W-1:0] ty;
		logic [TRG_W-1:0] r21;
		logic [TRG_W-1:0] r22;
		logic [LEN_W-1:0] tz;
	} link_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [dhlt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	logic drv_valid = 1'b0;
	joint_word_t drv_word = '0;
	logic rcv_ready = 1'b0;

	// Copy of the link constants as the block should hold them.
	logic [ANG_W-1:0] base_theta_q = '0;
	logic [ANG_W-1:0] base_alpha_q = '0;
	logic signed [LEN_W-1:0] base_a_q = '0;
	logic signed [LEN_W-1:0] base_d_q = '0;

	joint_word_t joint_pending [$];
	link_word_t link_expected [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;
	int link_count = 0;
	int quiet_cycles = 0;

	dhlt_joint_if joint_bus ();
	dhlt_link_if link_bus ();

	assign joint_bus.valid       = drv_valid;
	assign joint_bus.joint_theta = drv_word.theta;
	assign joint_bus.joint_alpha = drv_word.alpha;
	assign joint_bus.joint_a     = drv_word.len_a;
	assign joint_bus.joint_d     = drv_word.off_d;
	assign link_bus.ready        = rcv_ready;

	dh_link_transform_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.joint     (joint_bus),
		.link      (link_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Q30 product, rounded half up.
	function automatic logic [63:0] q30_product(input logic [63:0] x, input logic [63:0] y);
		return (x * y + (64'd1 << 29)) >> 30;
	endfunction

	// Quadrant folded odd polynomial of sin(t*pi/2), result in Q1.15.
	function automatic logic signed [TRG_W-1:0] sine_q15(input logic [ANG_W-1:0] ang);
		logic [1:0] quad;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] p;
		logic [63:0] v;
		logic [TRG_W-1:0] mag;
		quad = ang[ANG_W-1:ANG_W-2];
		t = 64'(ang[ANG_W-3:0]) << (32 - ANG_W);
		if (quad[0])
			t = (64'd1 << 30) - t;
		s = q30_product(t, t);
		p = SINE_C9;
		p = SINE_C7 - q30_product(p, s);
		p = SINE_C5 - q30_product(p, s);
		p = SINE_C3 - q30_product(p, s);
		p = SINE_C1 - q30_product(p, s);
		v = q30_product(p, t);
		v = (v + (64'd1 << 14)) >> 15;
		if (v > 64'd32767)
			v = 64'd32767;
		mag = v[TRG_W-1:0];
		return quad[1] ? -mag : mag;
	endfunction

	// Round half up, then drop fifteen fraction bits.
	function automatic longint round_q15(input longint x);
		return (x + 64'sd16384) >>> 15;
	endfunction

	function automatic longint clamp_length(input longint x);
		if (x > LEN_MAX)
			return LEN_MAX;
		if (x < LEN_MIN)
			return LEN_MIN;
		return x;
	endfunction

	// Link matrix entries for one joint word under the current constants.
	function automatic link_word_t predict_link(input joint_word_t j);
		logic [ANG_W-1:0] th;
		logic [ANG_W-1:0] al;
		longint a_sum;
		longint d_sum;
		longint st;
		longint ct;
		longint sa;
		longint ca;
		link_word_t w;
		th = base_theta_q + j.theta;
		al = base_alpha_q + j.alpha;
		a_sum = clamp_length(longint'(base_a_q) + longint'($signed(j.len_a)));
		d_sum = clamp_length(longint'(base_d_q) + longint'($signed(j.off_d)));
		st = sine_q15(th);
		ct = sine_q15(th + QUARTER_TURN);
		sa = sine_q15(al);
		ca = sine_q15(al + QUARTER_TURN);
		w.r00 = TRG_W'(ct);
		w.r01 = TRG_W'(round_q15(-(st * ca)));
		w.r02 = TRG_W'(round_q15(st * sa));
		w.tx  = LEN_W'(clamp_length(round_q15(a_sum * ct)));
		w.r10 = TRG_W'(st);
		w.r11 = TRG_W'(round_q15(ct * ca));
		w.r12 = TRG_W'(round_q15(-(ct * sa)));
		w.ty  = LEN_W'(clamp_length(round_q15(a_sum * st)));
		w.r21 = TRG_W'(sa);
		w.r22 = TRG_W'(ca);
		w.tz  = LEN_W'(d_sum);
		return w;
	endfunction

	function automatic logic [ANG_W-1:0] random_angle();
		if ($urandom_range(7) == 0)
			return ANG_W'(ANGLE_CORNERS[$urandom_range(7)]);
		return ANG_W'($urandom);
	endfunction

	// Mostly full range, with a share of corners and of small lengths.
	function automatic logic [LEN_W-1:0] random_length();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(7))
			0: begin
				v = LENGTH_CORNERS[$urandom_range(7)];
			end
			1, 2: begin
				v = {{12{v[19]}}, v[19:0]};
			end
			default: begin
			end
		endcase
		return LEN_W'(v);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_entry(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("link word %0d: %s is %h, predicted %h",
				link_count, name, got, want));
	endtask

	task automatic compare_link(input link_word_t want);
		link_word_t seen;
		seen = {link_bus.r00, link_bus.r01, link_bus.r02, link_bus.tx,
			link_bus.r10, link_bus.r11, link_bus.r12, link_bus.ty,
			link_bus.r21, link_bus.r22, link_bus.tz};
		check_entry("r00", 32'(seen.r00), 32'(want.r00));
		check_entry("r01", 32'(seen.r01), 32'(want.r01));
		check_entry("r02", 32'(seen.r02), 32'(want.r02));
		check_entry("tx", 32'(seen.tx), 32'(want.tx));
		check_entry("r10", 32'(seen.r10), 32'(want.r10));
		check_entry("r11", 32'(seen.r11), 32'(want.r11));
		check_entry("r12", 32'(seen.r12), 32'(want.r12));
		check_entry("ty", 32'(seen.ty), 32'(want.ty));
		check_entry("r21", 32'(seen.r21), 32'(want.r21));
		check_entry("r22", 32'(seen.r22), 32'(want.r22));
		check_entry("tz", 32'(seen.tz), 32'(want.tz));
	endtask

	task automatic queue_joint(input logic [ANG_W-1:0] th, input logic [ANG_W-1:0] al,
		input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d);
		joint_word_t j;
		j.theta = th;
		j.alpha = al;
		j.len_a = a;
		j.off_d = d;
		joint_pending.push_back(j);
	endtask

	task automatic queue_random_joints(input int count);
		for (int n = 0; n < count; n++)
			queue_joint(random_angle(), random_angle(), random_length(), random_length());
	endtask

	task automatic write_register(input dhlt_pkg::cfg_reg_t idx,
		input logic [CFG_W-1:0] value);
		case (idx)
			dhlt_pkg::CFG_BASE_THETA:    base_theta_q = value[ANG_W-1:0];
			dhlt_pkg::CFG_BASE_ALPHA:    base_alpha_q = value[ANG_W-1:0];
			dhlt_pkg::CFG_BASE_LENGTH_A: base_a_q = value[LEN_W-1:0];
			dhlt_pkg::CFG_BASE_OFFSET_D: base_d_q = value[LEN_W-1:0];
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	// Angle registers get random upper bits, which the block must drop.
	task automatic load_link_constants(input logic [ANG_W-1:0] th,
		input logic [ANG_W-1:0] al, input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] d);
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom);
		v[ANG_W-1:0] = th;
		write_register(dhlt_pkg::CFG_BASE_THETA, v);
		v = CFG_W'($urandom);
		v[ANG_W-1:0] = al;
		write_register(dhlt_pkg::CFG_BASE_ALPHA, v);
		write_register(dhlt_pkg::CFG_BASE_LENGTH_A, CFG_W'(a));
		write_register(dhlt_pkg::CFG_BASE_OFFSET_D, CFG_W'(d));
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(posedge clk);
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	// Waits until every joint word has been sent and every link word checked.
	task automatic drain_link();
		@(negedge clk);
		while (joint_pending.size() != 0 || drv_valid || link_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Joint driver: predicts each accepted word and offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			drv_word  <= '0;
		end else begin
			if (drv_valid && joint_bus.ready)
				link_expected.push_back(predict_link(drv_word));
			if (!drv_valid || joint_bus.ready) begin
				if (joint_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_valid <= 1'b1;
					drv_word  <= joint_pending.pop_front();
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Link monitor: checks each accepted word and throttles ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else begin
			if (link_bus.valid && rcv_ready) begin
				if (link_expected.size() == 0)
					report_mismatch($sformatf("link word %0d arrived with none predicted",
						link_count));
				else
					compare_link(link_expected.pop_front());
				link_count <= link_count + 1;
			end
			if (hold_seen != hold_requests) begin
				hold_seen <= hold_requests;
				hold_left <= HOLD_CYCLES;
				rcv_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rcv_ready <= 1'b0;
			end else begin
				rcv_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((drv_valid && joint_bus.ready) || (link_bus.valid && rcv_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(25, 51);

		// Constants at their reset value: quadrant edges and length extremes.
		@(negedge clk);
		queue_joint(16'h0000, 16'h0000, 32'h00000000, 32'h00000000);
		queue_joint(16'h4000, 16'h4000, LEN_MAX_WORD, LEN_MAX_WORD);
		queue_joint(16'h8000, 16'h8000, LEN_MIN_WORD, LEN_MIN_WORD);
		queue_joint(16'hC000, 16'hC000, 32'h00010000, 32'hFFFF0000);
		queue_joint(16'h7FFF, 16'h8001, 32'h00000001, 32'hFFFFFFFF);
		queue_joint(16'hFFFF, 16'h0001, LEN_MAX_WORD, 32'h00000000);
		queue_joint(16'h2000, 16'h6000, 32'h12345678, LEN_MIN_WORD);
		queue_joint(16'hA000, 16'hE000, LEN_MIN_WORD, LEN_MAX_WORD);
		queue_joint(16'h3FFF, 16'h4001, LEN_MAX_WORD, 32'h00000001);
		queue_joint(16'hBFFF, 16'hC001, LEN_MIN_WORD, 32'hFFFFFFFF);
		queue_joint(16'h0001, 16'hFFFF, 32'h55555555, 32'hAAAAAAAA);
		queue_joint(16'hAAAA, 16'h5555, 32'hAAAAAAAA, 32'h55555555);
		queue_random_joints(RANDOM_PER_SET);
		drain_link();

		// Largest constants: angle sums wrap and length sums clip high.
		load_link_constants(16'h7FFF, 16'h7FFF, LEN_MAX_WORD, LEN_MAX_WORD);
		@(negedge clk);
		queue_joint(16'h0001, 16'h7FFF, LEN_MAX_WORD, 32'h00000001);
		queue_joint(16'h8001, 16'h8000, LEN_MIN_WORD, LEN_MIN_WORD);
		queue_joint(16'hFFFF, 16'h0002, 32'h00000001, 32'hFFFFFFFF);
		queue_random_joints(RANDOM_PER_SET);
		drain_link();

		// Smallest constants: length sums clip low.
		set_idling(51, 25);
		load_link_constants(16'h8000, 16'h8000, LEN_MIN_WORD, LEN_MIN_WORD);
		@(negedge clk);
		queue_joint(16'h8000, 16'h7FFF, LEN_MIN_WORD, 32'hFFFFFFFF);
		queue_joint(16'hFFFF, 16'h0000, LEN_MAX_WORD, LEN_MAX_WORD);
		queue_joint(16'h0000, 16'hC000, 32'h00000000, LEN_MIN_WORD);
		queue_random_joints(RANDOM_PER_SET);
		drain_link();

		load_link_constants(random_angle(), random_angle(), random_length(), random_length());
		@(negedge clk);
		queue_random_joints(RANDOM_PER_SET);
		drain_link();

		// No idling; the receiver holds off long enough for the pipeline to fill.
		set_idling(0, 0);
		load_link_constants(random_angle(), random_angle(), random_length(), random_length());
		@(negedge clk);
		queue_random_joints(RANDOM_PER_SET);
		@(posedge clk);
		hold_requests <= hold_requests + 1;
		drain_link();

		load_link_constants(random_angle(), random_angle(), random_length(), random_length());
		@(negedge clk);
		queue_random_joints(RANDOM_PER_SET);
		drain_link();

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/dhlt_pkg.sv
design/dhlt_ifs.sv
design/dhlt_prep_cell.sv
design/dhlt_horner_cell.sv
design/dhlt_finish_cell.sv
design/dh_link_transform_core.sv
sim/tb_dh_link_transform_core.sv
